/* rtl/bldc_bemf_six_step_commutator_defines.svh */
`ifndef BLDC_BEMF_SIX_STEP_COMMUTATOR_DEFINES_SVH
`define BLDC_BEMF_SIX_STEP_COMMUTATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBSC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bbsc assertion failed");

// next-cycle implication, checked outside reset
`define BBSC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bbsc assertion failed");

`endif

/* rtl/bbsc_pkg.sv */
package bbsc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int INTERVAL_CAP = 40;
    localparam int START_COUNT = 50;
    localparam int SMOOTH_WIDTH = 6;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [0:0] REG_DIRECTION = 1'b0;
    localparam logic [0:0] REG_START_SMOOTH = 1'b1;
    localparam logic [SMOOTH_WIDTH-1:0] START_SMOOTH_RESET = 6'd8;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_START = 2'd2
    } op_t;

    typedef struct packed {
        logic direction;
        logic [SMOOTH_WIDTH-1:0] start_smoothed_interval;
    } cfg_t;

    typedef struct packed {
        logic [2:0] phase_pattern;
        logic commutated;
        logic [SMOOTH_WIDTH-1:0] smoothed_interval;
        logic start_failed;
    } result_t;

    localparam logic [2:0] SECTOR_OF_CODE [8] = '{3'd0, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd0};
    localparam logic [2:0] FWD_PHASE [8] = '{3'd0, 3'd1, 3'd6, 3'd5, 3'd2, 3'd4, 3'd3, 3'd0};
    localparam logic [2:0] REV_PHASE [8] = '{3'd0, 3'd5, 3'd4, 3'd1, 3'd3, 3'd6, 3'd2, 3'd0};
    localparam logic [2:0] PARK_STEP [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd6, 3'd3, 3'd0};
    localparam logic [2:0] FWD_ACCEL [8] = '{3'd0, 3'd1, 3'd3, 3'd5, 3'd5, 3'd6, 3'd3, 3'd0};
    localparam logic [2:0] REV_ACCEL [8] = '{3'd0, 3'd6, 3'd3, 3'd5, 3'd5, 3'd6, 3'd3, 3'd0};
    localparam logic [2:0] NEXT_CODE [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd7};
    localparam logic [2:0] FWD_MASK [8] = '{3'h0, 3'h2, 3'h4, 3'h1, 3'h1, 3'h4, 3'h2, 3'h0};
    localparam logic [2:0] REV_MASK [8] = '{3'h0, 3'h4, 3'h2, 3'h1, 3'h1, 3'h2, 3'h4, 3'h0};
    localparam logic WANT_HIGH [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    function automatic logic [2:0] drive_pattern(input logic [2:0] code, input logic dir);
        logic [2:0] sec;
        sec = SECTOR_OF_CODE[code];
        return dir ? REV_PHASE[sec] : FWD_PHASE[sec];
    endfunction

endpackage

/* rtl/bldc_bemf_six_step_commutator.sv */
// Sensorless six-step BLDC commutator. Requests are taken one per clock while in_ready is high,
// and each gives one result: the request is held in the input register, and then the table
// lookup, back-EMF match and interval filter settle into the result register. A new request can
// be taken as the last one moves on to the result register; in_ready drops only while both the
// input and result registers are full and out_ready is low. Configuration is over the APB port:
// direction at 0x0, start_smoothed_interval at 0x4, both readable back.
`include "bldc_bemf_six_step_commutator_defines.svh"

module bldc_bemf_six_step_commutator #(
    parameter int COUNT_WIDTH = bbsc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [bbsc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [bbsc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [bbsc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic pready,
    input  logic in_valid,
    output logic in_ready,
    input  logic [1:0] operation,
    input  logic [2:0] bemf_bits,
    input  logic [2:0] rotor_sector,
    output logic out_valid,
    input  logic out_ready,
    output logic [2:0] phase_pattern,
    output logic commutated,
    output logic [bbsc_pkg::SMOOTH_WIDTH-1:0] smoothed_interval,
    output logic start_failed
);

    bbsc_pkg::cfg_t cfg;
    bbsc_pkg::result_t result_next;
    bbsc_pkg::result_t result_reg;

    logic s1_valid_reg;
    logic [1:0] operation_reg;
    logic [2:0] bemf_bits_reg;
    logic [2:0] rotor_sector_reg;
    logic out_valid_reg;
    logic s1_go;

    logic [2:0] step_code_reg;
    logic [2:0] step_code_next;
    logic [COUNT_WIDTH-1:0] interval_count_reg;
    logic [COUNT_WIDTH-1:0] interval_count_next;
    logic [bbsc_pkg::SMOOTH_WIDTH-1:0] smoothed_value_reg;
    logic [bbsc_pkg::SMOOTH_WIDTH-1:0] smoothed_value_next;
    logic [2:0] pattern_reg;
    logic [2:0] pattern_next;

    assign pready = 1'b1;

    bbsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bbsc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .operation           (operation_reg),
        .bemf_bits           (bemf_bits_reg),
        .rotor_sector        (rotor_sector_reg),
        .cfg                 (cfg),
        .step_code           (step_code_reg),
        .interval_count      (interval_count_reg),
        .smoothed_value      (smoothed_value_reg),
        .pattern             (pattern_reg),
        .step_code_next      (step_code_next),
        .interval_count_next (interval_count_next),
        .smoothed_value_next (smoothed_value_next),
        .pattern_next        (pattern_next),
        .result              (result_next)
    );

    assign s1_go = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            step_code_reg <= 3'd1;
            interval_count_reg <= '0;
            smoothed_value_reg <= '0;
            pattern_reg <= 3'd0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            priority if (s1_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (s1_go)
            begin
                step_code_reg <= step_code_next;
                interval_count_reg <= interval_count_next;
                smoothed_value_reg <= smoothed_value_next;
                pattern_reg <= pattern_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            operation_reg <= operation;
            bemf_bits_reg <= bemf_bits;
            rotor_sector_reg <= rotor_sector;
        end
        if (s1_go)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign phase_pattern = result_reg.phase_pattern;
    assign commutated = result_reg.commutated;
    assign smoothed_interval = result_reg.smoothed_interval;
    assign start_failed = result_reg.start_failed;

    `BBSC_ASSERT_NOW(a_step_code_legal, clk, rst_n, 1'b1,
        (step_code_reg != 3'd0 && step_code_reg != 3'd7))
    `BBSC_ASSERT_NEXT(a_count_cleared, clk, rst_n, (s1_go && result_next.commutated),
        (interval_count_reg == '0))
    `BBSC_ASSERT_NOW(a_commutate_drives, clk, rst_n, (out_valid_reg && result_reg.commutated),
        (result_reg.phase_pattern != 3'd0 && !result_reg.start_failed))
    `BBSC_ASSERT_NEXT(a_state_holds, clk, rst_n, !s1_go,
        ($stable(step_code_reg) && $stable(pattern_reg)))

endmodule

/* rtl/bbsc_cfg.sv */
module bbsc_cfg (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [bbsc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [bbsc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [bbsc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output bbsc_pkg::cfg_t cfg
);

    bbsc_pkg::cfg_t cfg_reg;
    logic aligned;
    logic wr_en;

    assign aligned = (paddr[1:0] == 2'b00);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction <= 1'b0;
            cfg_reg.start_smoothed_interval <= bbsc_pkg::START_SMOOTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                bbsc_pkg::REG_DIRECTION: cfg_reg.direction <= pwdata[0];
                bbsc_pkg::REG_START_SMOOTH:
                    cfg_reg.start_smoothed_interval <= pwdata[bbsc_pkg::SMOOTH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (aligned)
        begin
            unique case (paddr[2])
                bbsc_pkg::REG_DIRECTION: prdata[0] = cfg_reg.direction;
                bbsc_pkg::REG_START_SMOOTH:
                    prdata[bbsc_pkg::SMOOTH_WIDTH-1:0] = cfg_reg.start_smoothed_interval;
                default: prdata = '0;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/bbsc_step.sv */
module bbsc_step #(
    parameter int COUNT_WIDTH = bbsc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic [1:0] operation,
    input  logic [2:0] bemf_bits,
    input  logic [2:0] rotor_sector,
    input  bbsc_pkg::cfg_t cfg,
    input  logic [2:0] step_code,
    input  logic [COUNT_WIDTH-1:0] interval_count,
    input  logic [bbsc_pkg::SMOOTH_WIDTH-1:0] smoothed_value,
    input  logic [2:0] pattern,
    output logic [2:0] step_code_next,
    output logic [COUNT_WIDTH-1:0] interval_count_next,
    output logic [bbsc_pkg::SMOOTH_WIDTH-1:0] smoothed_value_next,
    output logic [2:0] pattern_next,
    output bbsc_pkg::result_t result
);

    localparam logic [COUNT_WIDTH-1:0] CAP = COUNT_WIDTH'(bbsc_pkg::INTERVAL_CAP);
    localparam logic [COUNT_WIDTH-1:0] START_LOAD =
        (bbsc_pkg::START_COUNT > (2 ** COUNT_WIDTH) - 1) ? '1
                                                          : COUNT_WIDTH'(bbsc_pkg::START_COUNT);

    logic [COUNT_WIDTH-1:0] capped;
    logic [bbsc_pkg::SMOOTH_WIDTH-1:0] half;
    logic [bbsc_pkg::SMOOTH_WIDTH-1:0] filtered;
    logic [2:0] mask;
    logic match;
    logic [2:0] park_code;
    logic park_bad;
    logic [2:0] accel_code;
    logic fired;
    logic failed;

    always_comb
    begin
        capped = (interval_count > CAP) ? CAP : interval_count;
        half = {1'b0, capped[bbsc_pkg::SMOOTH_WIDTH-1:1]};
        if (smoothed_value < half)
            filtered = smoothed_value + 1'b1;
        else if (smoothed_value > half && smoothed_value > 6'd1)
            filtered = smoothed_value - 1'b1;
        else
            filtered = smoothed_value;
    end

    assign mask = cfg.direction ? bbsc_pkg::REV_MASK[step_code] : bbsc_pkg::FWD_MASK[step_code];
    assign match = (mask != 3'd0) && (((bemf_bits & mask) != 3'd0) == bbsc_pkg::WANT_HIGH[step_code]);
    assign park_code = bbsc_pkg::PARK_STEP[rotor_sector];
    assign park_bad = (rotor_sector == 3'd0) || (park_code == 3'd0) || (park_code == 3'd7);
    assign accel_code = cfg.direction ? bbsc_pkg::REV_ACCEL[rotor_sector]
                                      : bbsc_pkg::FWD_ACCEL[rotor_sector];

    always_comb
    begin
        step_code_next = step_code;
        interval_count_next = interval_count;
        smoothed_value_next = smoothed_value;
        pattern_next = pattern;
        fired = 1'b0;
        failed = 1'b0;
        unique case (bbsc_pkg::op_t'(operation))
            bbsc_pkg::OP_TICK:
            begin
                if (interval_count != '1)
                    interval_count_next = interval_count + 1'b1;
            end
            bbsc_pkg::OP_SAMPLE:
            begin
                if (match)
                begin
                    step_code_next = bbsc_pkg::NEXT_CODE[step_code];
                    pattern_next = bbsc_pkg::drive_pattern(step_code, cfg.direction);
                    smoothed_value_next = filtered;
                    interval_count_next = '0;
                    fired = 1'b1;
                end
            end
            bbsc_pkg::OP_START:
            begin
                if (park_bad)
                    failed = 1'b1;
                else
                begin
                    step_code_next = park_code;
                    interval_count_next = START_LOAD;
                    smoothed_value_next = cfg.start_smoothed_interval;
                    pattern_next = bbsc_pkg::drive_pattern(accel_code, cfg.direction);
                end
            end
            default: ;
        endcase
    end

    assign result.phase_pattern = pattern_next;
    assign result.commutated = fired;
    assign result.smoothed_interval = smoothed_value_next;
    assign result.start_failed = failed;

endmodule
